// ===== sv/stripcm_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stripcm_pkg
// Shared types and constants of the strip common-mode subtraction block.
// ---------------------------------------------------------------------------
package stripcm_pkg;

  // fixed field widths
  localparam int ADC_BITS    = 12;
  localparam int CORR_W      = ADC_BITS + 1;
  localparam int STRIP_NUM_W = 5;
  localparam int OFFSET_W    = 8;

  localparam logic [ADC_BITS-1:0] ADC_MAX      = '1;
  localparam logic [OFFSET_W-1:0] OFFSET_RESET = 8'd27;

  // scan pass select
  localparam logic [1:0] PASS_MIN  = 2'd0;
  localparam logic [1:0] PASS_MIN2 = 2'd1;
  localparam logic [1:0] PASS_SUM  = 2'd2;

  // input beat
  typedef struct packed {
    logic [ADC_BITS-1:0] strip_adc;
    logic                strip_is_hot;
    logic                last_strip;
  } in_beat_t;

  // output beat
  typedef struct packed {
    logic signed [CORR_W-1:0] corrected_adc;
    logic [ADC_BITS-1:0]      common_mode;
    logic [STRIP_NUM_W-1:0]   strip_number;
    logic                     run_end;
  } out_beat_t;

  // controller to datapath
  typedef struct packed {
    logic       start;
    logic       acc_en;
    logic [1:0] pass_sel;
    logic       div_load;
    logic       out_load;
    logic       out_last;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_done;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== sv/stripcm_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stripcm_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module stripcm_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/stripcm_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stripcm_ctrl
// Sequencer: strip loading, three scan passes, divide, and output burst.
// ---------------------------------------------------------------------------
module stripcm_ctrl #(
  parameter int STRIPS = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      last_strip,
  output logic                      in_stall,
  output logic                      in_we,
  output logic [$clog2(STRIPS)-1:0] wr_addr,
  output logic [$clog2(STRIPS)-1:0] rd_addr,
  output logic [$clog2(STRIPS)-1:0] acc_idx,
  output logic [$clog2(STRIPS)-1:0] out_idx,
  output stripcm_pkg::dp_cmd_t      cmd,
  input  stripcm_pkg::dp_stat_t     stat
);
  import stripcm_pkg::*;

  localparam int IDX_W = $clog2(STRIPS);
  localparam int CNT_W = $clog2(STRIPS + 1);
  localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(STRIPS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STRIPS - 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(STRIPS - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MIN   = 3'd1;
  localparam logic [2:0] S_MIN2  = 3'd2;
  localparam logic [2:0] S_SUM   = 3'd3;
  localparam logic [2:0] S_DIVLD = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_EMRD  = 3'd6;
  localparam logic [2:0] S_EMWR  = 3'd7;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] load_r, load_nxt;
  logic             acc_en_r, acc_en_nxt;
  logic [IDX_W-1:0] acc_idx_r, acc_idx_nxt;
  logic             in_acc;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && (state_r == S_IDLE);
  assign in_we    = in_acc;
  assign wr_addr  = load_r;
  assign rd_addr  = cnt_r[IDX_W-1:0];
  assign acc_idx  = acc_idx_r;
  assign out_idx  = cnt_r[IDX_W-1:0];

  // next-state and command decode
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    load_nxt     = load_r;
    acc_en_nxt   = 1'b0;
    acc_idx_nxt  = acc_idx_r;
    cmd          = '0;
    cmd.acc_en   = acc_en_r;
    cmd.pass_sel = PASS_MIN;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (last_strip) begin
            load_nxt  = '0;
            cnt_nxt   = '0;
            cmd.start = 1'b1;
            state_nxt = S_MIN;
          end else begin
            load_nxt = (load_r == IDX_LAST) ? '0 : load_r + 1'b1;
          end
        end
      end
      S_MIN, S_MIN2, S_SUM: begin
        case (state_r)
          S_MIN2:  cmd.pass_sel = PASS_MIN2;
          S_SUM:   cmd.pass_sel = PASS_SUM;
          default: cmd.pass_sel = PASS_MIN;
        endcase
        if (cnt_r != CNT_END) begin
          acc_en_nxt  = 1'b1;
          acc_idx_nxt = cnt_r[IDX_W-1:0];
          cnt_nxt     = cnt_r + 1'b1;
        end else begin
          // last read word is consumed this cycle
          cnt_nxt = '0;
          case (state_r)
            S_MIN:   state_nxt = S_MIN2;
            S_MIN2:  state_nxt = S_SUM;
            default: state_nxt = S_DIVLD;
          endcase
        end
      end
      S_DIVLD: begin
        cmd.div_load = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        if (stat.div_done) begin
          cnt_nxt   = '0;
          state_nxt = S_EMRD;
        end
      end
      S_EMRD: begin
        state_nxt = S_EMWR;
      end
      S_EMWR: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = (cnt_r == CNT_LAST);
          if (cnt_r == CNT_LAST) begin
            cnt_nxt   = '0;
            state_nxt = S_IDLE;
          end else begin
            cnt_nxt   = cnt_r + 1'b1;
            state_nxt = S_EMRD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      load_r   <= '0;
      acc_en_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      load_r   <= load_nxt;
      acc_en_r <= acc_en_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_idx_r <= acc_idx_nxt;
  end

endmodule

// ===== sv/stripcm_dp.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stripcm_dp
// Datapath: min / second-min / sum scans, restoring divider, output register.
// ---------------------------------------------------------------------------
module stripcm_dp #(
  parameter int STRIPS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [stripcm_pkg::OFFSET_W-1:0]    cfg_data,
  input  logic [stripcm_pkg::ADC_BITS:0]      rd_data,
  input  logic [$clog2(STRIPS)-1:0]           acc_idx,
  input  logic [$clog2(STRIPS)-1:0]           out_idx,
  input  stripcm_pkg::dp_cmd_t                cmd,
  output stripcm_pkg::dp_stat_t               stat,
  input  logic                                out_stall,
  output logic                                out_valid,
  output stripcm_pkg::out_beat_t              out_data
);
  import stripcm_pkg::*;

  localparam int IDX_W  = $clog2(STRIPS);
  localparam int CNT_W  = $clog2(STRIPS + 1);
  localparam int SUM_W  = ADC_BITS + CNT_W;
  localparam int NUM_W  = SUM_W + 1;
  localparam int DEN_W  = CNT_W + 1;
  localparam int DCNT_W = $clog2(NUM_W + 1);

  logic [OFFSET_W-1:0] offset_r, offset_nxt;
  logic [ADC_BITS-1:0] lo1_r, lo1_nxt;
  logic [IDX_W-1:0]    skip_r, skip_nxt;
  logic [ADC_BITS-1:0] lo2_r, lo2_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [CNT_W-1:0]    n_r, n_nxt;
  logic [NUM_W-1:0]    num_r, num_nxt;
  logic [DEN_W-1:0]    den_r, den_nxt;
  logic [DEN_W-1:0]    rem_r, rem_nxt;
  logic [DCNT_W-1:0]   dcnt_r, dcnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_beat_t           out_data_r, out_data_nxt;

  logic [ADC_BITS-1:0] rd_adc;
  logic                rd_hot;
  logic [ADC_BITS-1:0] est;
  logic [ADC_BITS:0]   thr;
  logic [DEN_W:0]      rem_sh;
  logic [ADC_BITS-1:0] cm;
  logic [CORR_W-1:0]   diff;

  assign rd_adc = rd_data[ADC_BITS-1:0];
  assign rd_hot = rd_data[ADC_BITS];
  assign est    = rd_hot ? ADC_MAX : rd_adc;
  assign thr    = {1'b0, lo2_r} + (ADC_BITS + 1)'(offset_r);
  assign rem_sh = {rem_r, num_r[NUM_W-1]};
  // quotient ends up in num_r once the divider has run
  assign cm     = num_r[ADC_BITS-1:0];
  assign diff   = {1'b0, rd_adc} - {1'b0, cm};

  assign stat.div_done = (dcnt_r == '0);
  assign stat.out_free = !out_valid_r || !out_stall;
  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;

  always_comb begin
    offset_nxt    = offset_r;
    lo1_nxt       = lo1_r;
    skip_nxt      = skip_r;
    lo2_nxt       = lo2_r;
    sum_nxt       = sum_r;
    n_nxt         = n_r;
    num_nxt       = num_r;
    den_nxt       = den_r;
    rem_nxt       = rem_r;
    dcnt_nxt      = dcnt_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    // config write
    if (cfg_we) begin
      offset_nxt = cfg_data;
    end

    // accumulator init for a new sensor
    if (cmd.start) begin
      lo2_nxt = ADC_MAX;
      sum_nxt = '0;
      n_nxt   = '0;
    end

    // scan passes
    if (cmd.acc_en) begin
      case (cmd.pass_sel)
        PASS_MIN: begin
          if (acc_idx == '0) begin
            lo1_nxt  = est;
            skip_nxt = '0;
          end else if (est < lo1_r) begin
            lo1_nxt  = est;
            skip_nxt = acc_idx;
          end
        end
        PASS_MIN2: begin
          if (acc_idx != skip_r && est < lo2_r) begin
            lo2_nxt = est;
          end
        end
        PASS_SUM: begin
          if (acc_idx != skip_r && {1'b0, est} <= thr) begin
            sum_nxt = sum_r + SUM_W'(est);
            n_nxt   = n_r + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    // divider: (2*sum + n) / (2*n), one quotient bit per cycle
    if (cmd.div_load) begin
      num_nxt  = {sum_r, 1'b0} + NUM_W'(n_r);
      den_nxt  = {n_r, 1'b0};
      rem_nxt  = '0;
      dcnt_nxt = DCNT_W'(NUM_W);
    end else if (dcnt_r != '0) begin
      if (rem_sh >= {1'b0, den_r}) begin
        rem_nxt = DEN_W'(rem_sh - {1'b0, den_r});
        num_nxt = {num_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[DEN_W-1:0];
        num_nxt = {num_r[NUM_W-2:0], 1'b0};
      end
      dcnt_nxt = dcnt_r - 1'b1;
    end

    // output register
    if (cmd.out_load) begin
      out_valid_nxt              = 1'b1;
      out_data_nxt.corrected_adc = $signed(diff);
      out_data_nxt.common_mode   = cm;
      out_data_nxt.strip_number  = STRIP_NUM_W'(out_idx);
      out_data_nxt.run_end       = cmd.out_last;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control and config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r    <= OFFSET_RESET;
      dcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      offset_r    <= offset_nxt;
      dcnt_r      <= dcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    lo1_r      <= lo1_nxt;
    skip_r     <= skip_nxt;
    lo2_r      <= lo2_nxt;
    sum_r      <= sum_nxt;
    n_r        <= n_nxt;
    num_r      <= num_nxt;
    den_r      <= den_nxt;
    rem_r      <= rem_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== sv/strip_common_mode_subtract.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// strip_common_mode_subtract
// Strips load at one beat per cycle into the sample RAM, but only while idle;
// in_stall is high otherwise. After the last strip: three scans (min,
// second-min, sum), a divider load, then ADC_BITS+$clog2(STRIPS+1)+1 divider steps.
// The output burst then does one RAM read per strip and waits on out_stall.
// Synchronous active-low reset: control idle, load slot 0, offset 27.
// ---------------------------------------------------------------------------
module strip_common_mode_subtract #(
  parameter int STRIPS = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  stripcm_pkg::in_beat_t            in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output stripcm_pkg::out_beat_t           out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [stripcm_pkg::OFFSET_W-1:0] cfg_data
);
  import stripcm_pkg::*;

  localparam int IDX_W = $clog2(STRIPS);

  logic             in_we;
  logic [IDX_W-1:0] wr_addr;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] acc_idx;
  logic [IDX_W-1:0] out_idx;
  logic [ADC_BITS:0] rd_data;
  dp_cmd_t          cmd;
  dp_stat_t         stat;

  assign cfg_ready = 1'b1;

  // sample store: {hot flag, adc}
  stripcm_ram #(
    .WIDTH(ADC_BITS + 1),
    .DEPTH(STRIPS)
  ) u_ram (
    .clk   (clk),
    .we    (in_we),
    .waddr (wr_addr),
    .wdata ({in_data.strip_is_hot, in_data.strip_adc}),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  stripcm_ctrl #(
    .STRIPS(STRIPS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .last_strip (in_data.last_strip),
    .in_stall   (in_stall),
    .in_we      (in_we),
    .wr_addr    (wr_addr),
    .rd_addr    (rd_addr),
    .acc_idx    (acc_idx),
    .out_idx    (out_idx),
    .cmd        (cmd),
    .stat       (stat)
  );

  stripcm_dp #(
    .STRIPS(STRIPS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .rd_data   (rd_data),
    .acc_idx   (acc_idx),
    .out_idx   (out_idx),
    .cmd       (cmd),
    .stat      (stat),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== sv/stripcm_chk.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stripcm_chk
// Port-level checks on the output burst and input backpressure.
// ---------------------------------------------------------------------------
module stripcm_chk #(
  parameter int STRIPS = 32
) (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_stall,
  input stripcm_pkg::in_beat_t            in_data,
  input logic                             out_valid,
  input logic                             out_stall,
  input stripcm_pkg::out_beat_t           out_data
);
  import stripcm_pkg::*;

  logic [STRIP_NUM_W-1:0] exp_num_r;
  logic [ADC_BITS-1:0]    cm_r;
  logic                   out_acc;

  assign out_acc = out_valid && !out_stall;

  // expected strip number and common mode of the running burst
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_num_r <= '0;
    end else if (out_acc) begin
      exp_num_r <= out_data.run_end ? '0 : exp_num_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_acc) begin
      cm_r <= out_data.common_mode;
    end
  end

  // the last strip starts the computation, input must back off
  a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.last_strip |=> in_stall)
    else $error("input not stalled after last strip");

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output beat changed");

  // strips leave in order, starting from zero
  a_strip_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.strip_number == exp_num_r)
    else $error("strip number out of sequence");

  // run_end marks exactly the final strip
  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.run_end ==
                   (out_data.strip_number == STRIP_NUM_W'(STRIPS - 1))))
    else $error("run_end does not match last strip");

  // one common mode for the whole burst
  a_cm_const: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.strip_number != '0 |-> out_data.common_mode == cm_r)
    else $error("common mode changed within burst");

endmodule

bind strip_common_mode_subtract stripcm_chk #(.STRIPS(STRIPS)) u_chk (.*);

// ===== dv/stripcm_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stripcm_checker
// Passive monitor for strip_common_mode_subtract. It tracks offset writes
// and loaded strips, predicts the corrected burst of each sensor when its
// last strip is taken, and compares every output beat field by field.
// ---------------------------------------------------------------------------
module stripcm_checker #(
  parameter int STRIPS = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  stripcm_pkg::in_beat_t            in_data,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  stripcm_pkg::out_beat_t           out_data,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [stripcm_pkg::OFFSET_W-1:0] cfg_data,
  output int                               fail_count,
  output int                               expected_left
);
  import stripcm_pkg::*;

  // shadow copy of the sensor RAM and control state
  logic [ADC_BITS-1:0] sample_mem [STRIPS];
  logic                hot_mem    [STRIPS];
  int                  load_slot;
  logic [OFFSET_W-1:0] offset_q;

  out_beat_t           pending_corrections [$];
  out_beat_t           predicted;
  out_beat_t           oldest;
  logic [ADC_BITS-1:0] cm;
  int                  mismatches = 0;

  assign fail_count = mismatches;

  task automatic report_mismatch(string field, int strip, int got, int wanted);
    $display("[%0t] mismatch strip %0d: %s got %0d, expected %0d",
             $time, strip, field, got, wanted);
    mismatches++;
  endtask

  // level a strip contributes to the estimate: hot strips read full scale
  function automatic int strip_level(int idx);
    return hot_mem[idx] ? int'(ADC_MAX) : int'(sample_mem[idx]);
  endfunction

  // rounded mean of the quiet strips, lowest strip left out
  function automatic logic [ADC_BITS-1:0] common_mode_estimate();
    int lowest, second, limit, total, count, skip, lvl;
    lowest = strip_level(0);
    skip   = 0;
    second = ADC_MAX;
    total  = 0;
    count  = 0;
    for (int i = 1; i < STRIPS; i++) begin
      lvl = strip_level(i);
      if (lvl < lowest) begin
        lowest = lvl;
        skip   = i;
      end
    end
    for (int i = 0; i < STRIPS; i++) begin
      lvl = strip_level(i);
      if (i != skip && lvl < second) second = lvl;
    end
    limit = second + int'(offset_q);
    for (int i = 0; i < STRIPS; i++) begin
      lvl = strip_level(i);
      if (i != skip && lvl <= limit) begin
        total += lvl;
        count++;
      end
    end
    // second-lowest strip always passes its own threshold, so count > 0
    return ADC_BITS'((2 * total + count) / (2 * count));
  endfunction

  // sample all channels at the clock edge
  always @(posedge clk) begin
    if (!rst_n) begin
      load_slot = 0;
      offset_q  = OFFSET_RESET;
      pending_corrections.delete();
    end else begin
      if (cfg_valid && cfg_ready) offset_q = cfg_data;

      // output beat against the oldest prediction
      if (out_valid && !out_stall) begin
        if (pending_corrections.size() == 0) begin
          report_mismatch("unexpected beat", int'(out_data.strip_number), 1, 0);
        end else begin
          oldest = pending_corrections.pop_front();
          if (out_data.corrected_adc !== oldest.corrected_adc)
            report_mismatch("corrected_adc", int'(oldest.strip_number),
                            int'(out_data.corrected_adc), int'(oldest.corrected_adc));
          if (out_data.common_mode !== oldest.common_mode)
            report_mismatch("common_mode", int'(oldest.strip_number),
                            int'(out_data.common_mode), int'(oldest.common_mode));
          if (out_data.strip_number !== oldest.strip_number)
            report_mismatch("strip_number", int'(oldest.strip_number),
                            int'(out_data.strip_number), int'(oldest.strip_number));
          if (out_data.run_end !== oldest.run_end)
            report_mismatch("run_end", int'(oldest.strip_number),
                            int'(out_data.run_end), int'(oldest.run_end));
        end
      end

      // input beat: store, and on the last strip predict the burst
      if (in_valid && !in_stall) begin
        sample_mem[load_slot] = in_data.strip_adc;
        hot_mem[load_slot]    = in_data.strip_is_hot;
        if (!in_data.last_strip) begin
          load_slot = (load_slot == STRIPS - 1) ? 0 : load_slot + 1;
        end else begin
          load_slot = 0;
          cm        = common_mode_estimate();
          for (int i = 0; i < STRIPS; i++) begin
            predicted.corrected_adc = {1'b0, sample_mem[i]} - {1'b0, cm};
            predicted.common_mode   = cm;
            predicted.strip_number  = STRIP_NUM_W'(i);
            predicted.run_end       = (i == STRIPS - 1);
            pending_corrections.push_back(predicted);
          end
        end
      end
    end
    expected_left <= pending_corrections.size();
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Stimulus and verdict for strip_common_mode_subtract. Directed sensors hit
// ties, hot strips, full scale, a wrapping overlong sensor and an early last
// strip; then three phases of random sensors under different offsets and
// idle patterns. The checker instance does all prediction and comparison.
// ---------------------------------------------------------------------------
module testbench;
  import stripcm_pkg::*;

  localparam int STRIPS          = 32;
  localparam int SETTLE_CYCLES   = 150;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int ITEMS_PER_PHASE = 13;

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  in_beat_t            in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_beat_t           out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [OFFSET_W-1:0] cfg_data  = '0;

  int fail_count;
  int expected_left;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int quiet_cycles   = 0;

  // sensor image being sent; room for overlong sensors that wrap
  logic [ADC_BITS-1:0] strip_val [64];
  logic                strip_hot [64];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  strip_common_mode_subtract #(.STRIPS(STRIPS)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  stripcm_checker #(.STRIPS(STRIPS)) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .expected_left (expected_left)
  );

  // receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // watchdog: cycles without any accepted beat or write
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one input beat, with optional idle cycles ahead of it
  task automatic send_beat(in_beat_t beat);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_sensor(int len);
    in_beat_t beat;
    for (int i = 0; i < len; i++) begin
      beat.strip_adc    = strip_val[i];
      beat.strip_is_hot = strip_hot[i];
      beat.last_strip   = (i == len - 1);
      send_beat(beat);
    end
  endtask

  task automatic write_offset(logic [OFFSET_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // wait until every predicted beat has come out, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_left != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // random sensor: mostly pedestal-like, some noise, short and overlong runs
  // length is capped at max_len
  task automatic random_sensor(input int max_len, output int len);
    int kind, base, spread, lvl;
    kind   = $urandom_range(0, 99);
    base   = $urandom_range(0, ADC_MAX);
    spread = $urandom_range(0, 80);
    if (kind < 10) len = $urandom_range(1, STRIPS - 1);
    else if (kind < 18) len = $urandom_range(STRIPS + 1, STRIPS + 12);
    else len = STRIPS;
    if (len > max_len) len = max_len;
    for (int i = 0; i < len; i++) begin
      lvl = base + $urandom_range(0, spread);
      if ((kind >= 18 && kind < 36) || $urandom_range(0, 99) < 5)
        strip_val[i] = ADC_BITS'($urandom_range(0, ADC_MAX));
      else
        strip_val[i] = (lvl > ADC_MAX) ? ADC_MAX : ADC_BITS'(lvl);
      strip_hot[i] = ($urandom_range(0, 99) < 6);
    end
    send_sensor(len);
  endtask

  task automatic run_phase(int idle_pct, int stall_pct, logic [OFFSET_W-1:0] offset);
    int items, len;
    items          = 0;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    write_offset(offset);
    while (items < ITEMS_PER_PHASE) begin
      random_sensor(ITEMS_PER_PHASE - items, len);
      items += len;
    end
    drain();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // pedestal with a tied minimum, a full-scale spike and a hot zero strip
    for (int i = 0; i < STRIPS; i++) begin
      strip_val[i] = ADC_BITS'(200 + $urandom_range(0, 20));
      strip_hot[i] = 1'b0;
    end
    strip_val[5]  = 150;
    strip_val[17] = 150;
    strip_val[9]  = ADC_MAX;
    strip_val[12] = 0;
    strip_hot[12] = 1'b1;
    send_sensor(STRIPS);

    // every strip hot, two extra strips wrap onto slots 0 and 1:
    // estimate is full scale, outputs go down to -4095
    for (int i = 0; i < STRIPS + 2; i++) begin
      strip_val[i] = ADC_BITS'(i * 120);
      strip_hot[i] = 1'b1;
    end
    strip_val[0]          = 0;
    strip_val[STRIPS - 1] = ADC_MAX;
    strip_val[STRIPS]     = 0;
    strip_val[STRIPS + 1] = ADC_MAX;
    send_sensor(STRIPS + 2);

    // early last strip: four zero strips, the rest left hot from above
    for (int i = 0; i < 4; i++) begin
      strip_val[i] = 0;
      strip_hot[i] = 1'b0;
    end
    send_sensor(4);
    drain();

    run_phase(12, 68, 8'd255);
    run_phase(68, 12, OFFSET_W'($urandom_range(1, 254)));
    run_phase(0, 0, 8'd0);

    if (fail_count == 0 && expected_left == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
